>>> rtl/core/ppic_pkg.sv
// Package: shared codes, constants and request/response types of the PPI port controller.
`timescale 1ns / 1ps

package ppic_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 4;
    localparam int KEY_ROWS_DEF = 16;

    // Access operations
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_KEY_ROW = 2'd2;

    // Port addresses
    localparam logic [1:0] PORT_A    = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_C    = 2'd2;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // Sound chip actions
    localparam logic [1:0] PSG_NONE   = 2'd0;
    localparam logic [1:0] PSG_SELECT = 2'd1;
    localparam logic [1:0] PSG_WRITE  = 2'd2;

    // Port C bits 7..6: sound chip bus mode
    localparam logic [1:0] PSG_MODE_READ   = 2'b01;
    localparam logic [1:0] PSG_MODE_WRITE  = 2'b10;
    localparam logic [1:0] PSG_MODE_SELECT = 2'b11;

    // Sound chip register that routes the key matrix onto port A
    localparam logic [3:0] PSG_KEY_REG = 4'd14;

    // Port B read: bits 1..4 forced high, bits 5..6 forced low
    localparam logic [BYTE_W-1:0] PB_FORCE_ONE = 8'h1E;
    localparam logic [BYTE_W-1:0] PB_KEEP      = 8'h9F;

    // Control word: port C bit that starts the motor
    localparam logic [2:0] MOTOR_BIT = 3'd4;

    localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] BYTE_ONES    = 8'hFF;

    // One bus request
    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        port;
        logic [BYTE_W-1:0] data;
        logic [ROW_W-1:0]  key_row;
        logic [3:0]        psg_register;
        logic [BYTE_W-1:0] psg_read_data;
        logic              tape_playing;
        logic [BYTE_W-1:0] tape_level;
    } t_req;

    // One response
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [1:0]        psg_action;
        logic [BYTE_W-1:0] psg_data;
        logic              motor_start;
        logic [BYTE_W-1:0] port_c_value;
    } t_rsp;

    // Key matrix row write
    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] data;
    } t_key_wr;

endpackage

>>> rtl/core/ppi_port_controller_core.sv
// Top level of the PPI port controller: request register, port unit, response register.
// A request waits in the request register; its response goes to the response register.
// Throughput: one request per cycle while the receiver takes responses (i_out_ready).
// Reset (synchronous, active low): ports A/B/C zero, key rows all ones, threshold 128.
// Reset empties both stages; the configuration port is always ready.
`timescale 1ns / 1ps

module ppi_port_controller_core
    import ppic_pkg::*;
#(
    parameter int KEY_ROWS = KEY_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_op,
    input  logic [1:0]        i_port,
    input  logic [BYTE_W-1:0] i_data,
    input  logic [ROW_W-1:0]  i_key_row,
    input  logic [3:0]        i_psg_register,
    input  logic [BYTE_W-1:0] i_psg_read_data,
    input  logic              i_tape_playing,
    input  logic [BYTE_W-1:0] i_tape_level,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_read_data,
    output logic [1:0]        o_psg_action,
    output logic [BYTE_W-1:0] o_psg_data,
    output logic              o_motor_start,
    output logic [BYTE_W-1:0] o_port_c_value
);

    logic r_req_valid;
    t_req r_req;
    logic r_out_valid;
    t_rsp r_out;
    t_rsp rsp;
    logic req_fire;

    // Stage 1 moves on whenever the response register is free or draining
    assign req_fire    = r_req_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_req_valid || req_fire;
    assign o_cfg_ready = 1'b1;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.op            <= i_op;
            r_req.port          <= i_port;
            r_req.data          <= i_data;
            r_req.key_row       <= i_key_row;
            r_req.psg_register  <= i_psg_register;
            r_req.psg_read_data <= i_psg_read_data;
            r_req.tape_playing  <= i_tape_playing;
            r_req.tape_level    <= i_tape_level;
        end
    end

    ppic_port_unit #(
        .KEY_ROWS (KEY_ROWS)
    ) u_ports (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (req_fire),
        .i_req      (r_req),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (rsp)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out.read_data;
    assign o_psg_action   = r_out.psg_action;
    assign o_psg_data     = r_out.psg_data;
    assign o_motor_start  = r_out.motor_start;
    assign o_port_c_value = r_out.port_c_value;

endmodule

>>> rtl/core/ppic_key_matrix.sv
// Key matrix: one byte per keyboard row, all keys released after reset.
`timescale 1ns / 1ps

module ppic_key_matrix
    import ppic_pkg::*;
#(
    parameter int KEY_ROWS = KEY_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_key_wr           i_wr,
    input  logic [ROW_W-1:0]  i_rd_row,
    output logic [BYTE_W-1:0] o_rd_data
);

    localparam int IDX_W = $clog2(KEY_ROWS);

    logic [BYTE_W-1:0] r_rows [KEY_ROWS];
    logic              wr_hit;
    logic              rd_hit;

    // Rows beyond the populated matrix are ignored on write, read as released
    assign wr_hit = i_wr.en && (32'(i_wr.row) < KEY_ROWS);
    assign rd_hit = 32'(i_rd_row) < KEY_ROWS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_ROWS; i++) begin
                r_rows[i] <= BYTE_ONES;
            end
        end else if (wr_hit) begin
            r_rows[i_wr.row[IDX_W-1:0]] <= i_wr.data;
        end
    end

    assign o_rd_data = rd_hit ? r_rows[i_rd_row[IDX_W-1:0]] : BYTE_ONES;

endmodule

>>> rtl/core/ppic_port_unit.sv
// Port unit: port A/B/C registers, tape threshold and the per-request decode.
`timescale 1ns / 1ps

module ppic_port_unit
    import ppic_pkg::*;
#(
    parameter int KEY_ROWS = KEY_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data,
    output t_rsp              o_rsp
);

    logic [BYTE_W-1:0] r_port_a;
    logic [BYTE_W-1:0] r_port_b;
    logic [BYTE_W-1:0] r_port_c;
    logic [BYTE_W-1:0] r_thresh;
    logic [BYTE_W-1:0] n_port_a;
    logic [BYTE_W-1:0] n_port_b;
    logic [BYTE_W-1:0] n_port_c;
    logic [BYTE_W-1:0] key_data;
    logic [BYTE_W-1:0] port_b_rd;
    t_key_wr           key_wr;
    t_rsp              rsp;

    ppic_key_matrix #(
        .KEY_ROWS (KEY_ROWS)
    ) u_keys (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (key_wr),
        .i_rd_row  (r_port_c[ROW_W-1:0]),
        .o_rd_data (key_data)
    );

    // Key row update request
    always_comb begin
        key_wr.en   = i_fire && (i_req.op == OP_KEY_ROW);
        key_wr.row  = i_req.key_row;
        key_wr.data = i_req.data;
    end

    // Port B readback: fixed bits, tape level at or above threshold in bit 7 while playing
    always_comb begin
        port_b_rd = (r_port_b | PB_FORCE_ONE) & PB_KEEP;
        if (i_req.tape_playing) begin
            port_b_rd[BYTE_W-1] = (i_req.tape_level >= r_thresh);
        end
    end

    // Request decode and next port state
    always_comb begin
        n_port_a        = r_port_a;
        n_port_b        = r_port_b;
        n_port_c        = r_port_c;
        rsp.read_data   = BYTE_ONES;
        rsp.psg_action  = PSG_NONE;
        rsp.psg_data    = '0;
        rsp.motor_start = 1'b0;
        case (i_req.op)
            OP_READ: begin
                case (i_req.port)
                    PORT_A: begin
                        if (r_port_c[7:6] == PSG_MODE_READ) begin
                            if (i_req.psg_register == PSG_KEY_REG) begin
                                rsp.read_data = key_data;
                            end else if (i_req.psg_register < PSG_KEY_REG) begin
                                rsp.read_data = i_req.psg_read_data;
                            end
                        end
                    end
                    PORT_B:  rsp.read_data = port_b_rd;
                    PORT_C:  rsp.read_data = r_port_c;
                    default: rsp.read_data = BYTE_ONES;
                endcase
            end
            OP_WRITE: begin
                case (i_req.port)
                    PORT_A: n_port_a = i_req.data;
                    PORT_B: n_port_b = i_req.data;
                    PORT_C: begin
                        case (i_req.data[7:6])
                            PSG_MODE_SELECT: begin
                                rsp.psg_action = PSG_SELECT;
                                rsp.psg_data   = r_port_a;
                            end
                            PSG_MODE_WRITE: begin
                                rsp.psg_action = PSG_WRITE;
                                rsp.psg_data   = r_port_a;
                            end
                            default: rsp.psg_action = PSG_NONE;
                        endcase
                        n_port_c = i_req.data;
                    end
                    default: begin
                        // Control word: mode set clears ports, else bit set/reset on C
                        if (i_req.data[7]) begin
                            n_port_a = '0;
                            n_port_b = '0;
                            n_port_c = '0;
                        end else begin
                            n_port_c[i_req.data[3:1]] = i_req.data[0];
                            rsp.motor_start = (i_req.data[3:1] == MOTOR_BIT) && i_req.data[0];
                        end
                    end
                endcase
            end
            default: rsp.read_data = BYTE_ONES;
        endcase
        rsp.port_c_value = n_port_c;
    end

    assign o_rsp = rsp;

    // Port state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a <= '0;
            r_port_b <= '0;
            r_port_c <= '0;
        end else if (i_fire) begin
            r_port_a <= n_port_a;
            r_port_b <= n_port_b;
            r_port_c <= n_port_c;
        end
    end

    // Tape threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

endmodule

>>> rtl/core/ppic_checker.sv
// Checker: port-level properties of the PPI port controller, bound to the top level.
`timescale 1ns / 1ps

module ppic_checker
    import ppic_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] o_read_data,
    input logic [1:0]        o_psg_action,
    input logic [BYTE_W-1:0] o_psg_data,
    input logic              o_motor_start,
    input logic [BYTE_W-1:0] o_port_c_value
);

    // A stalled response stays valid and holds its read data, sound action and port C value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_psg_action) && $stable(o_port_c_value))
        else $error("stalled response changed");

    // No sound action means no sound data, and the action code is a real one
    a_psg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_psg_action == PSG_NONE && o_psg_data == '0)
            || o_psg_action == PSG_SELECT || o_psg_action == PSG_WRITE)
        else $error("bad sound chip action");

    // Motor pulse only on a control write: no read data, no sound action, C bit 4 set
    a_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motor_start |-> o_read_data == BYTE_ONES
            && o_psg_action == PSG_NONE && o_port_c_value[MOTOR_BIT])
        else $error("motor pulse on wrong access");

    // Reset empties the response register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

endmodule

bind ppi_port_controller_core ppic_checker u_ppic_checker (.*);

>>> sim/tb_ppi_port_controller_core.sv
// Testbench for the PPI port controller core: directed and random bus requests, self-checked.
`timescale 1ns / 1ps

module tb_ppi_port_controller_core;
    import ppic_pkg::*;

    // Unused op code, answers like a non-read access
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Port model and queue of responses still due from the block
    class ppi_scoreboard;
        logic [BYTE_W-1:0] thresh;
        logic [BYTE_W-1:0] pa, pb, pc, ctrl;
        logic [BYTE_W-1:0] keys [KEY_ROWS_DEF];
        t_rsp rsp_due_q [$];
        int mismatches;

        function new();
            thresh = THRESH_RESET;
            pa = '0;
            pb = '0;
            pc = '0;
            ctrl = '0;
            foreach (keys[i]) keys[i] = BYTE_ONES;
            mismatches = 0;
        endfunction

        function void set_threshold(logic [BYTE_W-1:0] v);
            thresh = v;
        endfunction

        function int pending();
            return rsp_due_q.size();
        endfunction

        // Apply one accepted request and queue the response it must produce
        function void note_request(t_req r);
            t_rsp e;
            logic [2:0] bit_sel;
            e.read_data    = BYTE_ONES;
            e.psg_action   = PSG_NONE;
            e.psg_data     = '0;
            e.motor_start  = 1'b0;
            case (r.op)
                OP_READ: begin
                    case (r.port)
                        PORT_A: begin
                            if (pc[7:6] == PSG_MODE_READ) begin
                                if (r.psg_register == PSG_KEY_REG)
                                    e.read_data = (int'(pc[3:0]) < KEY_ROWS_DEF) ?
                                                  keys[pc[3:0]] : BYTE_ONES;
                                else if (r.psg_register < PSG_KEY_REG)
                                    e.read_data = r.psg_read_data;
                            end
                        end
                        PORT_B: begin
                            e.read_data = (pb | PB_FORCE_ONE) & PB_KEEP;
                            if (r.tape_playing)
                                e.read_data[7] = (r.tape_level >= thresh);
                        end
                        PORT_C: e.read_data = pc;
                        default: e.read_data = BYTE_ONES;
                    endcase
                end
                OP_WRITE: begin
                    case (r.port)
                        PORT_A: pa = r.data;
                        PORT_B: pb = r.data;
                        PORT_C: begin
                            if (r.data[7:6] == PSG_MODE_SELECT) begin
                                e.psg_action = PSG_SELECT;
                                e.psg_data   = pa;
                            end else if (r.data[7:6] == PSG_MODE_WRITE) begin
                                e.psg_action = PSG_WRITE;
                                e.psg_data   = pa;
                            end
                            pc = r.data;
                        end
                        default: begin
                            ctrl = r.data;
                            if (r.data[7]) begin
                                pa = '0;
                                pb = '0;
                                pc = '0;
                            end else begin
                                // bit set / reset of one port C bit
                                bit_sel = r.data[3:1];
                                pc[bit_sel] = r.data[0];
                                if (bit_sel == MOTOR_BIT && r.data[0])
                                    e.motor_start = 1'b1;
                            end
                        end
                    endcase
                end
                OP_KEY_ROW: begin
                    if (int'(r.key_row) < KEY_ROWS_DEF) keys[r.key_row] = r.data;
                end
                default: ;
            endcase
            e.port_c_value = pc;
            rsp_due_q.push_back(e);
        endfunction

        // Compare one response with the oldest one due
        function void check_response(t_rsp got);
            t_rsp e;
            bit bad;
            if (rsp_due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with nothing pending: rd=%h act=%0d pd=%h mot=%b pc=%h",
                             got.read_data, got.psg_action, got.psg_data,
                             got.motor_start, got.port_c_value);
                return;
            end
            e = rsp_due_q.pop_front();
            bad = (got.read_data !== e.read_data) || (got.psg_action !== e.psg_action) ||
                  (got.psg_data !== e.psg_data) || (got.motor_start !== e.motor_start) ||
                  (got.port_c_value !== e.port_c_value);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp rd=%h act=%0d pd=%h mot=%b pc=%h",
                             e.read_data, e.psg_action, e.psg_data, e.motor_start,
                             e.port_c_value);
                    $display("         got rd=%h act=%0d pd=%h mot=%b pc=%h",
                             got.read_data, got.psg_action, got.psg_data,
                             got.motor_start, got.port_c_value);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [BYTE_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_op = '0;
    logic [1:0]        i_port = '0;
    logic [BYTE_W-1:0] i_data = '0;
    logic [ROW_W-1:0]  i_key_row = '0;
    logic [3:0]        i_psg_register = '0;
    logic [BYTE_W-1:0] i_psg_read_data = '0;
    logic              i_tape_playing = 1'b0;
    logic [BYTE_W-1:0] i_tape_level = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BYTE_W-1:0] o_read_data;
    logic [1:0]        o_psg_action;
    logic [BYTE_W-1:0] o_psg_data;
    logic              o_motor_start;
    logic [BYTE_W-1:0] o_port_c_value;

    ppi_scoreboard sb = new();
    int  in_idle_pct  = 28;
    int  out_idle_pct = 28;
    bit  hold_pending = 1'b0;
    int  cycle_count  = 0;

    ppi_port_controller_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_port         (i_port),
        .i_data         (i_data),
        .i_key_row      (i_key_row),
        .i_psg_register (i_psg_register),
        .i_psg_read_data(i_psg_read_data),
        .i_tape_playing (i_tape_playing),
        .i_tape_level   (i_tape_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_psg_action   (o_psg_action),
        .o_psg_data     (o_psg_data),
        .o_motor_start  (o_motor_start),
        .o_port_c_value (o_port_c_value)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Monitors: config writes, accepted requests, accepted responses
    always @(posedge i_clk) begin
        t_req r;
        t_rsp p;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_threshold(i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                r.op            = i_op;
                r.port          = i_port;
                r.data          = i_data;
                r.key_row       = i_key_row;
                r.psg_register  = i_psg_register;
                r.psg_read_data = i_psg_read_data;
                r.tape_playing  = i_tape_playing;
                r.tape_level    = i_tape_level;
                sb.note_request(r);
            end
            if (o_out_valid && i_out_ready) begin
                p.read_data    = o_read_data;
                p.psg_action   = o_psg_action;
                p.psg_data     = o_psg_data;
                p.motor_start  = o_motor_start;
                p.port_c_value = o_port_c_value;
                sb.check_response(p);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    function automatic t_req make_req(input logic [1:0] op, input logic [1:0] port,
                                      input logic [7:0] data, input logic [3:0] row,
                                      input logic [3:0] preg, input logic [7:0] prd,
                                      input logic play, input logic [7:0] lvl);
        t_req r;
        r.op            = op;
        r.port          = port;
        r.data          = data;
        r.key_row       = row;
        r.psg_register  = preg;
        r.psg_read_data = prd;
        r.tape_playing  = play;
        r.tape_level    = lvl;
        return r;
    endfunction

    // Random request, biased toward the paths that reach key rows and sound data
    function automatic t_req random_req(input logic [7:0] thr);
        t_req r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)      r.op = OP_READ;
        else if (pick < 80) r.op = OP_WRITE;
        else if (pick < 95) r.op = OP_KEY_ROW;
        else                r.op = OP_UNUSED;
        r.port = 2'($urandom_range(3));
        r.data = 8'($urandom);
        if (r.op == OP_WRITE && r.port == PORT_C && $urandom_range(1))
            r.data[7:6] = PSG_MODE_READ;
        r.key_row = 4'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)      r.psg_register = PSG_KEY_REG;
        else if (pick < 80) r.psg_register = 4'($urandom_range(13));
        else                r.psg_register = 4'd15;
        r.psg_read_data = 8'($urandom);
        r.tape_playing  = 1'($urandom);
        if ($urandom_range(99) < 30) r.tape_level = thr + 8'($urandom_range(2)) - 8'd1;
        else                         r.tape_level = 8'($urandom);
        return r;
    endfunction

    // Offer one request; valid is only lowered when a gap is taken
    task automatic send_req(input t_req r);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_op            <= r.op;
        i_port          <= r.port;
        i_data          <= r.data;
        i_key_row       <= r.key_row;
        i_psg_register  <= r.psg_register;
        i_psg_read_data <= r.psg_read_data;
        i_tape_playing  <= r.tape_playing;
        i_tape_level    <= r.tape_level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [BYTE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        logic [BYTE_W-1:0] phase_thr [RAND_PHASES];
        phase_thr[0] = 8'd0;
        phase_thr[1] = 8'd255;
        phase_thr[2] = 8'($urandom);
        phase_thr[3] = 8'd1;
        phase_thr[4] = 8'd254;
        phase_thr[5] = 8'($urandom);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset threshold
        send_req(make_req(OP_READ,  PORT_A,    8'h00, 4'd0,  4'd14, 8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_B,    8'h00, 4'd0,  4'd0,  8'h00, 1'b0, 8'hFF));
        send_req(make_req(OP_READ,  PORT_B,    8'h00, 4'd0,  4'd0,  8'h00, 1'b1, 8'd128));
        send_req(make_req(OP_READ,  PORT_B,    8'h00, 4'd0,  4'd0,  8'h00, 1'b1, 8'd127));
        send_req(make_req(OP_READ,  PORT_C,    8'h00, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_CTRL, 8'h00, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_KEY_ROW, PORT_A,  8'h00, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_KEY_ROW, PORT_A,  8'hA5, 4'd15, 4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_A,    8'hFF, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_B,    8'hFF, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_B,    8'h00, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_B,    8'h00, 4'd0,  4'd0,  8'h00, 1'b1, 8'h00));
        send_req(make_req(OP_WRITE, PORT_C,    8'hC0, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_C,    8'h80, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_C,    8'h40, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_A,    8'h00, 4'd0,  4'd14, 8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_A,    8'h00, 4'd0,  4'd3,  8'h5A, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_A,    8'h00, 4'd0,  4'd15, 8'h5A, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_C,    8'h4F, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_READ,  PORT_A,    8'h00, 4'd0,  4'd14, 8'h00, 1'b0, 8'h00));
        // Motor pulse on setting port C bit 4, none on clearing it
        send_req(make_req(OP_WRITE, PORT_CTRL, 8'h09, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_CTRL, 8'h08, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_CTRL, 8'h7F, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_WRITE, PORT_CTRL, 8'h80, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00));
        send_req(make_req(OP_UNUSED, PORT_C,   8'hFF, 4'd15, 4'd15, 8'hFF, 1'b1, 8'hFF));
        send_req(make_req(OP_READ,  PORT_A,    8'h00, 4'd0,  4'd14, 8'h00, 1'b0, 8'h00));
        wait_idle();

        // Random phases, one threshold each
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_threshold(phase_thr[ph]);
            if (ph == 2) begin
                // receiver holds off while the sender keeps pushing
                in_idle_pct  = 0;
                hold_pending = 1'b1;
            end
            if (ph == 3) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 60) in_idle_pct = 28;
                send_req(random_req(phase_thr[ph]));
            end
            in_idle_pct  = 28;
            out_idle_pct = 28;
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
